// ===== sv/task_runtime_statistics_defines.svh =====
// Assertion macros shared by the task runtime statistics RTL.
// No dependencies.
`ifndef TASK_RUNTIME_STATISTICS_DEFINES_SVH
`define TASK_RUNTIME_STATISTICS_DEFINES_SVH

// property holds while out of reset
`define TRS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// condition implies property on the next cycle, while out of reset
`define TRS_ASSERT_NEXT(lbl, cond, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |=> (prop)) else $error(msg);

`endif

// ===== sv/trs_pkg.sv =====
// Types and constants for the task runtime statistics block.
// No dependencies.
`default_nettype none
package trs_pkg;
  typedef enum logic [2:0] {
    OP_START = 3'd0, OP_END = 3'd1, OP_QWAIT = 3'd2, OP_QUERY = 3'd3, OP_CLEAR = 3'd4
  } op_e;
  typedef enum logic [1:0] {
    ST_APPLIED = 2'd0, ST_UNTRACKED = 2'd1, ST_NO_START = 2'd2, ST_NO_RECORD = 2'd3
  } status_e;
  typedef enum logic [2:0] {
    S_IDLE, S_READ, S_CALC, S_DIV, S_EST, S_WRITE, S_OUT
  } state_e;
  typedef struct packed {
    logic [31:0] qmax, qtot, last_ms, est, avg, mx, mn, tot, cnt;
  } rec_t;
  localparam logic [31:0] AllOnes = 32'hFFFF_FFFF;
  localparam logic [15:0] MaskReset = 16'h005F;
  localparam int unsigned InW = 3 + 4 + 32 * 3;
  localparam int unsigned OutW = 2 + 1 + 32 * 9;
endpackage
`default_nettype wire

// ===== sv/task_runtime_statistics.sv =====
// Task runtime statistics: per-task run and queue-wait records in one memory.
// Depends on trs_pkg and task_runtime_statistics_defines.svh.
//
// channel | dir | fields (lsb first)
// s_axis  | in  | tdata: op, task_id, now_us, now_ms, wait_us
// m_axis  | out | tdata: status, record_present, runs .. last_run_ms
// cfg     | in  | tracked_mask
//
// An end that updates a record passes through S_READ, S_CALC, the radix-2
// average divider in S_DIV, S_EST, S_WRITE and S_OUT; every other item skips
// S_DIV and S_EST. The next item is taken the cycle after the result is
// delivered, so one item is finished before the next is accepted.
// Reset clears valid and pending flags; the record memory is not cleared.
// A stalled result holds in the output register; no new item is taken
// until it is delivered.
`default_nettype none
`include "task_runtime_statistics_defines.svh"
module task_runtime_statistics import trs_pkg::*; #(
  parameter int unsigned NUM_TASKS = 16
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                s_axis_tvalid,
  output logic                     s_axis_tready,
  input  wire logic [103:0]        s_axis_tdata,   // op, task_id, now_us, now_ms, wait_us, 0
  output logic                     m_axis_tvalid,
  input  wire logic                m_axis_tready,
  output logic [295:0]             m_axis_tdata,   // status, present, runs, total, avg,
                                                   // min, max, est, qtot, qmax, last_ms, 0
  input  wire logic                cfg_we_i,
  input  wire logic [15:0]         cfg_wdata_i
);
  localparam int unsigned IdxW = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;

  state_e state_q, state_d;
  logic [15:0] mask_q;
  logic [NUM_TASKS-1:0] valid_q, pend_q;
  rec_t mem [NUM_TASKS];
  logic [31:0] stime [NUM_TASKS];
  rec_t rd_q, rec_q;
  rec_t fresh, rec_run, rec_fin, rec_qw;
  logic [31:0] st_rd_q;
  logic [2:0] op_q;
  logic [3:0] tid_q;
  logic [31:0] us_q, ms_q, wt_q, dur_q;
  logic [IdxW-1:0] idx;
  logic inrange;
  logic [1:0] status_q;
  logic [1:0] calc_status;
  logic upd_q, calc_upd;
  logic [5:0] cnt_q;
  logic [31:0] quo_q, dvs_q;
  logic [32:0] rem_q;
  logic [32:0] rem_sh;
  logic [35:0] est_q, eq_q;
  logic [OutW-1:0] out_q;
  logic ovld_q;

  assign idx = IdxW'(tid_q);
  assign inrange = ({28'd0, tid_q} < 32'(NUM_TASKS));
  assign s_axis_tready = (state_q == S_IDLE) && !ovld_q;
  assign m_axis_tvalid = ovld_q;
  assign m_axis_tdata = {{(296 - OutW){1'b0}}, out_q};

  always_comb begin
    fresh = rd_q;
    if (!valid_q[idx]) begin
      fresh = '0;
      fresh.mn = AllOnes;
    end
    calc_status = ST_APPLIED;
    calc_upd = 1'b0;
    if (op_q == OP_CLEAR) calc_status = ST_APPLIED;
    else if (!inrange) calc_status = ST_UNTRACKED;
    else if (op_q == OP_END) begin
      if (!pend_q[idx]) calc_status = ST_NO_START;
      else if (!mask_q[tid_q]) calc_status = ST_UNTRACKED;
      else calc_upd = 1'b1;
    end else if (op_q == OP_QWAIT) begin
      if (!mask_q[tid_q]) calc_status = ST_UNTRACKED;
      else calc_upd = 1'b1;
    end else if (op_q != OP_START) begin
      calc_status = valid_q[idx] ? ST_APPLIED : ST_NO_RECORD;
    end
    rec_run = rec_q;
    rec_run.cnt = rec_q.cnt + 32'd1;
    rec_run.tot = rec_q.tot + dur_q;
    if (dur_q < rec_q.mn) rec_run.mn = dur_q;
    if (dur_q > rec_q.mx) rec_run.mx = dur_q;
    rec_fin = rec_q;
    rec_fin.avg = (dvs_q == 32'd0) ? AllOnes : quo_q;
    rec_fin.est = (rec_q.est == 32'd0) ? dur_q : eq_q[31:0];
    rec_fin.last_ms = ms_q;
    rec_qw = rec_q;
    rec_qw.qtot = rec_q.qtot + wt_q;
    if (wt_q > rec_q.qmax) rec_qw.qmax = wt_q;
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (s_axis_tvalid && s_axis_tready) state_d = S_READ;
      S_READ:  state_d = S_CALC;
      S_CALC:  state_d = (op_q == OP_END && calc_upd) ? S_DIV : S_WRITE;
      S_DIV:   if (cnt_q == 6'd32) state_d = S_EST;
      S_EST:   state_d = S_WRITE;
      S_WRITE: state_d = S_OUT;
      S_OUT:   state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  assign rem_sh = {rem_q[31:0], quo_q[31]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      mask_q <= MaskReset;
      valid_q <= '0;
      pend_q <= '0;
      ovld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) mask_q <= cfg_wdata_i;
      if (ovld_q && m_axis_tready) ovld_q <= 1'b0;
      if (state_q == S_WRITE && inrange) begin
        if (op_q == OP_START) pend_q[idx] <= 1'b1;
        if (op_q == OP_END && upd_q) pend_q[idx] <= 1'b0;
        if (upd_q) valid_q[idx] <= 1'b1;
      end
      if (state_q == S_WRITE && op_q == OP_CLEAR) valid_q <= '0;
      if (state_q == S_OUT) ovld_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && s_axis_tvalid && s_axis_tready) begin
      op_q <= s_axis_tdata[2:0];
      tid_q <= s_axis_tdata[6:3];
      us_q <= s_axis_tdata[38:7];
      ms_q <= s_axis_tdata[70:39];
      wt_q <= s_axis_tdata[102:71];
    end
    rd_q <= mem[idx];
    st_rd_q <= stime[idx];
    unique case (state_q)
      S_CALC: begin
        rec_q <= fresh;
        upd_q <= calc_upd;
        status_q <= calc_status;
        dur_q <= us_q - st_rd_q;
        cnt_q <= '0;
      end
      S_DIV: begin
        if (cnt_q == 6'd0) begin
          rec_q <= rec_run;
          quo_q <= rec_run.tot;
          dvs_q <= rec_run.cnt;
          rem_q <= '0;
          est_q <= 36'd7 * {4'd0, rec_q.est} + 36'd3 * {4'd0, dur_q};
        end else begin
          if (rem_sh >= {1'b0, dvs_q}) begin
            rem_q <= rem_sh - {1'b0, dvs_q};
            quo_q <= {quo_q[30:0], 1'b1};
          end else begin
            rem_q <= rem_sh;
            quo_q <= {quo_q[30:0], 1'b0};
          end
          // divide by ten: shift-add reciprocal, then one correction
          case (cnt_q)
            6'd1: eq_q <= (est_q >> 1) + (est_q >> 2);
            6'd2: eq_q <= eq_q + (eq_q >> 4);
            6'd3: eq_q <= eq_q + (eq_q >> 8);
            6'd4: eq_q <= eq_q + (eq_q >> 16);
            6'd5: eq_q <= eq_q + (eq_q >> 32);
            6'd6: eq_q <= eq_q >> 3;
            6'd7: est_q <= est_q - ({eq_q[34:0], 1'b0} + {eq_q[32:0], 3'b000});
            6'd8: if (est_q > 36'd9) eq_q <= eq_q + 36'd1;
            default: ;
          endcase
        end
        cnt_q <= cnt_q + 6'd1;
      end
      S_EST: begin
        rec_q <= rec_fin;
      end
      S_WRITE: begin
        if (op_q == OP_QWAIT && upd_q) rec_q <= rec_qw;
      end
      default: ;
    endcase
    if (state_q == S_WRITE && inrange) begin
      if (op_q == OP_START) stime[idx] <= us_q;
      if (upd_q) mem[idx] <= (op_q == OP_QWAIT) ? rec_qw : rec_q;
    end
  end

  // result register, loaded in S_OUT with the status and, when a record exists, the record in rec_q
  always_ff @(posedge clk_i) begin
    if (state_q == S_OUT) begin
      if ((op_q != OP_CLEAR) && inrange && (valid_q[idx] || upd_q))
        out_q <= {rec_q.last_ms, rec_q.qmax, rec_q.qtot, rec_q.est, rec_q.mx,
                  rec_q.mn, rec_q.avg, rec_q.tot, rec_q.cnt, 1'b1, status_q};
      else
        out_q <= {{(OutW - 2){1'b0}}, status_q};
    end
  end

  `TRS_ASSERT(a_no_accept_busy, s_axis_tready |-> state_q == S_IDLE, "accept while busy")
  `TRS_ASSERT_NEXT(a_out_held, ovld_q && !m_axis_tready, ovld_q && $stable(out_q), "result lost")
  `TRS_ASSERT(a_div_len, state_q == S_DIV |-> cnt_q <= 6'd32, "divider overrun")
endmodule
`default_nettype wire

// ===== bench/task_runtime_statistics_test.sv =====
// Testbench for task_runtime_statistics: directed table then random events,
// every result checked against a behavioural model of the per-task records or a fixed table answer.
// Depends on trs_pkg and the task_runtime_statistics RTL.
`default_nettype none
module task_runtime_statistics_test;
  import trs_pkg::*;

  localparam int unsigned NT = 16;
  localparam int unsigned WDOG_LIMIT = 20000;
  localparam int unsigned N_RANDOM = 1730;

  typedef struct packed {
    logic [31:0] wait_us, now_ms, now_us;
    logic [3:0]  task_id;
    logic [2:0]  op;
  } event_t;

  typedef struct packed {
    logic [31:0] last_ms, qmax, qtot, est, mx, mn, avg, tot, cnt;
    logic        present;
    logic [1:0]  status;
  } answer_t;

  typedef struct {
    event_t  ev;
    logic    fixed;
    answer_t ans;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [103:0] s_axis_tdata = '0;  // op, task_id, now_us, now_ms, wait_us, 0
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [295:0] m_axis_tdata;       // status, present, runs, total, avg, min, max, est,
                                    // qtot, qmax, last_ms, 0
  logic cfg_we_i = 1'b0;
  logic [15:0] cfg_wdata_i = '0;

  task_runtime_statistics dut (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .cfg_we_i, .cfg_wdata_i
  );

  // model state
  logic [15:0] mask_m;
  logic        rec_ok [NT];
  logic        pend [NT];
  logic [31:0] t0 [NT];
  logic [31:0] r_cnt [NT], r_tot [NT], r_avg [NT], r_mn [NT], r_mx [NT];
  logic [31:0] r_est [NT], r_ms [NT], r_qtot [NT], r_qmax [NT];

  answer_t answers_due [$];
  int errors = 0;
  int idle_in = 0, idle_out = 0;  // percent
  int hold_off = 0;
  logic stall_go = 1'b0;
  logic stall_taken = 1'b0;
  int wdog = 0;
  logic done = 1'b0;

  initial forever #6 clk_i = ~clk_i;

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    errors++;
    $display("MISMATCH %s: got %h want %h at %0t", what, got, want, $realtime);
  endtask

  function automatic answer_t record_of(int t, status_e st);
    answer_t a;
    a = '0;
    a.status = st;
    if (rec_ok[t]) begin
      a.present = 1'b1;
      a.cnt = r_cnt[t]; a.tot = r_tot[t]; a.avg = r_avg[t];
      a.mn = r_mn[t]; a.mx = r_mx[t]; a.est = r_est[t];
      a.qtot = r_qtot[t]; a.qmax = r_qmax[t]; a.last_ms = r_ms[t];
    end
    return a;
  endfunction

  function automatic void open_record(int t);
    if (!rec_ok[t]) begin
      rec_ok[t] = 1'b1;
      r_cnt[t] = '0; r_tot[t] = '0; r_avg[t] = '0; r_mn[t] = AllOnes; r_mx[t] = '0;
      r_est[t] = '0; r_ms[t] = '0; r_qtot[t] = '0; r_qmax[t] = '0;
    end
  endfunction

  function automatic answer_t apply_event(event_t ev);
    int t;
    status_e st;
    logic [31:0] dur;
    logic [35:0] mix;
    t = ev.task_id;
    st = ST_APPLIED;
    case (ev.op)
      OP_CLEAR: begin
        foreach (rec_ok[i]) rec_ok[i] = 1'b0;
      end
      OP_START: begin
        t0[t] = ev.now_us;
        pend[t] = 1'b1;
      end
      OP_END: begin
        if (!pend[t]) st = ST_NO_START;
        else if (!mask_m[t]) st = ST_UNTRACKED;
        else begin
          dur = ev.now_us - t0[t];
          open_record(t);
          r_cnt[t] += 1;
          r_tot[t] += dur;
          r_avg[t] = (r_cnt[t] != 0) ? r_tot[t] / r_cnt[t] : AllOnes;
          if (dur < r_mn[t]) r_mn[t] = dur;
          if (dur > r_mx[t]) r_mx[t] = dur;
          if (r_est[t] == 0) r_est[t] = dur;
          else begin
            mix = (36'(r_est[t]) * 7 + 36'(dur) * 3) / 10;
            r_est[t] = mix[31:0];
          end
          r_ms[t] = ev.now_ms;
          pend[t] = 1'b0;
        end
      end
      OP_QWAIT: begin
        if (!mask_m[t]) st = ST_UNTRACKED;
        else begin
          open_record(t);
          r_qtot[t] += ev.wait_us;
          if (ev.wait_us > r_qmax[t]) r_qmax[t] = ev.wait_us;
        end
      end
      default: st = rec_ok[t] ? ST_APPLIED : ST_NO_RECORD;
    endcase
    return record_of(t, st);
  endfunction

  // input side: valid stays up between items unless the sender idles
  task automatic offer(event_t ev, logic fixed, answer_t want);
    if ($urandom_range(99) < idle_in) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
      while ($urandom_range(99) < idle_in) @(negedge clk_i);
    end
    s_axis_tdata <= 104'(ev);
    s_axis_tvalid <= 1'b1;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    answers_due.push_back(fixed ? want : apply_event(ev));
    @(negedge clk_i);
  endtask

  task automatic send(event_t ev);
    offer(ev, 1'b0, '0);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (answers_due.size() != 0) @(negedge clk_i);
    repeat (60) @(negedge clk_i);
  endtask

  task automatic set_mask(logic [15:0] m);
    drain();
    cfg_wdata_i <= m;
    cfg_we_i <= 1'b1;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    mask_m = m;
  endtask

  function automatic event_t random_event();
    event_t ev;
    int r;
    ev.task_id = $urandom_range(15);
    ev.now_us = $urandom;
    ev.now_ms = $urandom;
    ev.wait_us = ($urandom_range(3) == 0) ? $urandom : $urandom_range(5000);
    r = $urandom_range(99);
    if (r < 35) ev.op = OP_START;
    else if (r < 72) ev.op = OP_END;
    else if (r < 87) ev.op = OP_QWAIT;
    else if (r < 95) ev.op = OP_QUERY;
    else if (r < 97) ev.op = OP_CLEAR;
    else ev.op = 3'($urandom_range(5, 7));
    return ev;
  endfunction

  // output side
  always @(negedge clk_i) begin
    if (stall_go && !stall_taken) begin
      stall_taken <= 1'b1;
      hold_off <= 400;
      m_axis_tready <= 1'b0;
    end else if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      m_axis_tready <= 1'b0;
    end else m_axis_tready <= ($urandom_range(99) >= idle_out);
  end

  always @(posedge clk_i) begin
    answer_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata[290:0];
      if (answers_due.size() == 0) begin
        report("unexpected result", '0, '0);
      end else begin
        want = answers_due.pop_front();
        if (got.status !== want.status) report("status", 32'(got.status), 32'(want.status));
        if (got.present !== want.present) report("present", 32'(got.present), 32'(want.present));
        if (got.cnt !== want.cnt) report("runs", got.cnt, want.cnt);
        if (got.tot !== want.tot) report("total", got.tot, want.tot);
        if (got.avg !== want.avg) report("avg", got.avg, want.avg);
        if (got.mn !== want.mn) report("min", got.mn, want.mn);
        if (got.mx !== want.mx) report("max", got.mx, want.mx);
        if (got.est !== want.est) report("predicted", got.est, want.est);
        if (got.qtot !== want.qtot) report("qwait_total", got.qtot, want.qtot);
        if (got.qmax !== want.qmax) report("qwait_max", got.qmax, want.qmax);
        if (got.last_ms !== want.last_ms) report("last_ms", got.last_ms, want.last_ms);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || done)
      wdog <= 0;
    else if (wdog >= WDOG_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else wdog <= wdog + 1;
  end

  function automatic row_t mk(op_e op, int t, logic [31:0] us, logic [31:0] ms,
                              logic [31:0] w);
    row_t r;
    r.ev.op = op; r.ev.task_id = 4'(t); r.ev.now_us = us; r.ev.now_ms = ms;
    r.ev.wait_us = w;
    r.fixed = 1'b0;
    r.ans = '0;
    return r;
  endfunction

  function automatic row_t mk_fixed(op_e op, int t, logic [31:0] us, status_e st);
    row_t r;
    r = mk(op, t, us, '0, '0);
    r.fixed = 1'b1;
    r.ans.status = st;
    return r;
  endfunction

  row_t table_rows [$];

  initial begin
    event_t ev;
    answer_t a;
    row_t rw;
    foreach (rec_ok[i]) begin
      rec_ok[i] = 0; pend[i] = 0; t0[i] = 0;
    end
    mask_m = MaskReset;
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // after reset: no records, no pending starts
    table_rows.push_back(mk_fixed(OP_QUERY, 0, '0, ST_NO_RECORD));
    table_rows.push_back(mk_fixed(OP_END, 15, AllOnes, ST_NO_START));
    table_rows.push_back(mk_fixed(OP_QWAIT, 7, '0, ST_UNTRACKED));
    table_rows.push_back(mk(OP_START, 0, AllOnes, '0, '0));
    table_rows.push_back(mk(OP_END, 0, 32'd99, 32'd5, '0));        // wrapped duration
    table_rows.push_back(mk(OP_START, 0, 32'd1000, '0, '0));
    table_rows.push_back(mk(OP_END, 0, 32'd1000, AllOnes, '0));    // zero duration
    table_rows.push_back(mk(OP_START, 1, '0, '0, '0));
    table_rows.push_back(mk(OP_END, 1, AllOnes, 32'd7, '0));       // longest run
    table_rows.push_back(mk(OP_START, 1, '0, '0, '0));
    table_rows.push_back(mk(OP_END, 1, AllOnes, 32'd8, '0));
    table_rows.push_back(mk(OP_QWAIT, 2, '0, '0, AllOnes));
    table_rows.push_back(mk(OP_QWAIT, 2, '0, '0, 32'd3));          // total wraps
    table_rows.push_back(mk(OP_QWAIT, 3, '0, '0, '0));
    table_rows.push_back(mk(OP_START, 5, 32'd10, '0, '0));
    table_rows.push_back(mk(OP_END, 5, 32'd20, '0, '0));           // untracked end
    table_rows.push_back(mk(OP_QUERY, 1, '0, '0, '0));
    table_rows.push_back(mk(OP_QUERY, 9, '0, '0, '0));
    table_rows.push_back(mk(op_e'(3'd7), 0, '0, '0, '0));          // undefined op
    table_rows.push_back(mk(op_e'(3'd5), 2, '0, '0, '0));
    table_rows.push_back(mk_fixed(OP_CLEAR, 1, '0, ST_APPLIED));
    table_rows.push_back(mk_fixed(OP_QUERY, 1, '0, ST_NO_RECORD));
    foreach (table_rows[i]) begin
      ev = table_rows[i].ev;
      if (table_rows[i].fixed) begin
        a = apply_event(ev);
        if (a !== table_rows[i].ans) report("table row", 32'(i), 32'(a.status));
        offer(ev, 1'b1, table_rows[i].ans);
      end else send(ev);
    end

    // task 5 still pending: end it once tracked
    set_mask(16'hFFFF);
    rw = mk(OP_END, 5, 32'd50, 32'd1, '0);
    send(rw.ev);

    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin idle_in = 0; idle_out = 0; end
        1: begin idle_in = 63; idle_out = 0; end
        2: begin idle_in = 0; idle_out = 63; end
        default: begin idle_in = 10; idle_out = 10; end
      endcase
      case (ph)
        2: set_mask(16'h0000);
        4: set_mask(16'($urandom));
        6: set_mask(MaskReset);
        default: ;
      endcase
      if (ph == 1) stall_go = 1'b1;
      for (int n = 0; n < N_RANDOM / 8; n++) begin
        send(random_event());
        if (n == 100 && ph == 3) drain();
      end
    end
    idle_out = 0;
    drain();
    done = 1'b1;
    if (errors == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end
endmodule
`default_nettype wire

// ===== files.f =====
+incdir+sv
sv/trs_pkg.sv
sv/task_runtime_statistics.sv
bench/task_runtime_statistics_test.sv
